[rtl/core/bfgs_pkg.sv]
// shared types, constants and helpers of the bfgs inverse hessian step unit
package bfgs_pkg;

	localparam int MAX_COORDS_DEF = 16;
	localparam int FRAC_W         = 20;
	localparam int DATA_W         = 32;
	localparam int ACC_W          = 50;
	localparam int DIV_NUM_W      = 34;
	localparam int DIV_DVD_W      = DIV_NUM_W + FRAC_W;

	localparam logic [4:0]  ACTIVE_RESET = 5'd16;
	localparam logic [30:0] LIMIT_RESET  = 31'd104858;

	// command codes
	localparam logic [2:0] FN_LOAD_VEC    = 3'd0;
	localparam logic [2:0] FN_LOAD_HESS   = 3'd1;
	localparam logic [2:0] FN_UPDATE      = 3'd2;
	localparam logic [2:0] FN_STEP        = 3'd3;
	localparam logic [2:0] FN_READ_HESS   = 3'd4;
	localparam logic [2:0] FN_READ_COORD  = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SKIP = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// register indexes
	localparam logic REG_ACTIVE = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_OUT,
		ST_PREP_RD,
		ST_PREP_WR,
		ST_DOT_RD,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_DOT_END,
		ST_C_DIV1,
		ST_C_WAIT1,
		ST_C_DIV2,
		ST_C_WAIT2,
		ST_E_ROW_RD,
		ST_E_ROW_LAT,
		ST_E_RD,
		ST_E_M1,
		ST_E_M2,
		ST_E_M3,
		ST_E_M4,
		ST_E_M5,
		ST_E_M6,
		ST_E_DIV,
		ST_E_WAIT,
		ST_E_WR,
		ST_S_CRD,
		ST_S_CWR,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		PS_HY,
		PS_HTY,
		PS_SY,
		PS_YHY,
		PS_STEP
	} pass_t;

	typedef struct packed {
		logic              ovf;
		logic [DATA_W-1:0] val;
	} sat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < -64'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r.ovf = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/bfgs_ram.sv]
// generic single write port ram with registered read
module bfgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bfgs_div.sv]
// radix-2 restoring divider computing (num * 2^20) / den, truncated toward zero
module bfgs_div
	import bfgs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [DIV_NUM_W-1:0]   num,
	input  logic signed [DATA_W-1:0]      den,
	output logic signed [DIV_DVD_W:0]     quot,
	output div_stat_t                     stat
);

	localparam int CNT_W = $clog2(DIV_DVD_W + 1);

	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    dmag_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] mag_n;
	logic [DATA_W-1:0]    mag_d;
	logic [DATA_W:0]      trial;

	assign mag_n = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
	assign mag_d = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]} - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {mag_n, {FRAC_W{1'b0}}};
			rem_q  <= '0;
			dmag_q <= mag_d;
			neg_q  <= num[DIV_NUM_W-1] ^ den[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], dvd_q[DIV_DVD_W-1]};
				dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/core/bfgs_inverse_hessian_step_unit.sv]
// top level of the bfgs inverse hessian step unit
// loads are written to storage as they are accepted; reads pass the addressed entry through
//   a result register and then into the output register when the output is free
// update time is set by the n*n matrix walk, where each entry goes through the shared
//   multiplier and a divide
// step walks the n*n matrix with one shared multiply per matrix entry
// one command at a time; arst_n clears the sequencer, output valid and the two registers,
//   the vector and matrix storage holds no reset value
module bfgs_inverse_hessian_step_unit
	import bfgs_pkg::*;
#(
	parameter int MAX_COORDS = MAX_COORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// row, col, coord, prev_coord, grad, prev_grad, hess_value
	input  logic [167:0] s_tdata,
	// func
	input  logic [2:0]   s_tuser,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// data, status, zero fill
	output logic [39:0]  m_tdata,
	// configuration writes
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [30:0]  cfg_wdata
);

	localparam int IW     = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
	localparam int CW     = $clog2(MAX_COORDS + 1);
	localparam int VDEPTH = 1 << IW;
	localparam int HDEPTH = 1 << (2 * IW);

	// input fields
	logic [2:0]               in_func;
	logic [3:0]               in_row;
	logic [3:0]               in_col;
	logic [DATA_W-1:0]        in_coord;
	logic [DATA_W-1:0]        in_prev_coord;
	logic [DATA_W-1:0]        in_grad;
	logic [DATA_W-1:0]        in_prev_grad;
	logic [DATA_W-1:0]        in_hess_value;
	logic                     accept;
	logic                     row_ok;
	logic                     col_ok;
	logic [IW-1:0]            in_ri;
	logic [IW-1:0]            in_ci;

	// control state
	state_t                   state_q, state_d;
	pass_t                    pass_q;
	logic [IW-1:0]            i_q, j_q;
	logic [4:0]               active_q;
	logic [30:0]              limit_q;
	logic                     out_valid_q;
	logic [CW-1:0]            n_w;
	logic                     n_zero;
	logic [IW-1:0]            n_m1;
	logic                     last_i, last_j;

	// datapath registers
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;
	logic signed [DATA_W-1:0] sy_q, yhy_q, c_q, ss_q, a_q, si_q, wyi_q, d_q;
	logic [DATA_W-1:0]        res_data_q, out_data_q;
	logic [1:0]               res_status_q, out_status_q;
	logic                     use_sat_q, rd_hess_q, rd_ok_q;

	// ram ports
	logic signed [DATA_W-1:0] cc_rd, oc_rd, cg_rd, og_rd, hs_rd, sv_rd, yv_rd, wy_rd, wt_rd;
	logic                     vec_we, cc_we, hs_we, sy_we, wy_we, wt_we;
	logic [IW-1:0]            cc_waddr, cc_raddr, vsel_raddr;
	logic [2*IW-1:0]          hs_waddr, hs_raddr;
	logic [DATA_W-1:0]        cc_wdata, hs_wdata;

	// shared multiplier and divider
	logic signed [DATA_W-1:0]    mul_a, mul_b;
	logic signed [43:0]          fx_w;
	logic                        div_start;
	logic signed [DIV_NUM_W-1:0] div_num;
	logic signed [DIV_DVD_W:0]   div_quot;
	div_stat_t                   div_stat;

	// saturation results
	sat_t                     s_sat, y_sat, acc_sat, fx_sat, q_sat, h_new, coord_sum;
	logic signed [ACC_W-1:0]  neg_acc, lim_w, clamp_w;

	assign in_func       = s_tuser;
	assign in_row        = s_tdata[3:0];
	assign in_col        = s_tdata[7:4];
	assign in_coord      = s_tdata[39:8];
	assign in_prev_coord = s_tdata[71:40];
	assign in_grad       = s_tdata[103:72];
	assign in_prev_grad  = s_tdata[135:104];
	assign in_hess_value = s_tdata[167:136];
	assign accept        = s_tvalid && s_tready;
	assign row_ok        = 32'(in_row) < 32'(MAX_COORDS);
	assign col_ok        = 32'(in_col) < 32'(MAX_COORDS);
	assign in_ri         = IW'(in_row);
	assign in_ci         = IW'(in_col);

	// number of coordinates in use, limited to the built size
	always_comb begin
		if (32'(active_q) > 32'(MAX_COORDS)) begin
			n_w = CW'(MAX_COORDS);
		end else begin
			n_w = CW'(active_q);
		end
	end
	assign n_zero = (n_w == '0);
	assign n_m1   = IW'(n_w - CW'(1));
	assign last_i = (i_q == n_m1);
	assign last_j = (j_q == n_m1);

	// arithmetic around the shared units
	assign fx_w      = prod_q[63:FRAC_W];  // floor of product / 2^20
	assign fx_sat    = sat32(64'(fx_w));
	assign acc_sat   = sat32(64'(acc_q));
	assign q_sat     = sat32(64'(div_quot));
	assign s_sat     = sat32(64'(cc_rd) - 64'(oc_rd));
	assign y_sat     = sat32(64'(cg_rd) - 64'(og_rd));
	assign h_new     = sat32(64'(hs_rd) + 64'(a_q) - 64'(signed'(q_sat.val)));
	assign coord_sum = sat32(64'(cc_rd) + 64'(d_q));
	assign neg_acc   = -acc_q;
	assign lim_w     = {{(ACC_W-31){1'b0}}, limit_q};

	// step clamp to plus or minus the limit, no flag
	always_comb begin
		if (neg_acc > lim_w) begin
			clamp_w = lim_w;
		end else if (neg_acc < -lim_w) begin
			clamp_w = -lim_w;
		end else begin
			clamp_w = neg_acc;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_func)
						FN_UPDATE:     state_d = n_zero ? ST_FINISH : ST_PREP_RD;
						FN_STEP:       state_d = n_zero ? ST_FINISH : ST_DOT_RD;
						FN_READ_HESS:  state_d = ST_RD_OUT;
						FN_READ_COORD: state_d = ST_RD_OUT;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_OUT:  state_d = ST_FINISH;
			ST_PREP_RD: state_d = ST_PREP_WR;
			ST_PREP_WR: state_d = last_j ? ST_DOT_RD : ST_PREP_RD;
			ST_DOT_RD:  state_d = ST_DOT_MUL;
			ST_DOT_MUL: state_d = ST_DOT_ACC;
			ST_DOT_ACC: state_d = last_j ? ST_DOT_END : ST_DOT_RD;
			ST_DOT_END: begin
				case (pass_q)
					PS_HY, PS_HTY, PS_SY: state_d = ST_DOT_RD;
					PS_YHY:  state_d = (sy_q == '0) ? ST_FINISH : ST_C_DIV1;
					PS_STEP: state_d = ST_S_CRD;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_C_DIV1:    state_d = ST_C_WAIT1;
			ST_C_WAIT1:   state_d = div_stat.done ? ST_C_DIV2 : ST_C_WAIT1;
			ST_C_DIV2:    state_d = ST_C_WAIT2;
			ST_C_WAIT2:   state_d = div_stat.done ? ST_E_ROW_RD : ST_C_WAIT2;
			ST_E_ROW_RD:  state_d = ST_E_ROW_LAT;
			ST_E_ROW_LAT: state_d = ST_E_RD;
			ST_E_RD:      state_d = ST_E_M1;
			ST_E_M1:      state_d = ST_E_M2;
			ST_E_M2:      state_d = ST_E_M3;
			ST_E_M3:      state_d = ST_E_M4;
			ST_E_M4:      state_d = ST_E_M5;
			ST_E_M5:      state_d = ST_E_M6;
			ST_E_M6:      state_d = ST_E_DIV;
			ST_E_DIV:     state_d = ST_E_WAIT;
			ST_E_WAIT:    state_d = div_stat.done ? ST_E_WR : ST_E_WAIT;
			ST_E_WR: begin
				if (!last_j) begin
					state_d = ST_E_RD;
				end else begin
					state_d = last_i ? ST_FINISH : ST_E_ROW_RD;
				end
			end
			ST_S_CRD:  state_d = ST_S_CWR;
			ST_S_CWR:  state_d = last_i ? ST_FINISH : ST_DOT_RD;
			ST_FINISH: state_d = (!out_valid_q || m_tready) ? ST_IDLE : ST_FINISH;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, memory ports, shared unit operands
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		vec_we    = accept && (in_func == FN_LOAD_VEC) && row_ok;
		cc_we     = vec_we || (state_q == ST_S_CWR);
		cc_waddr  = (state_q == ST_IDLE) ? in_ri : i_q;
		cc_wdata  = (state_q == ST_IDLE) ? in_coord : coord_sum.val;
		hs_we     = (accept && (in_func == FN_LOAD_HESS) && row_ok && col_ok)
		            || (state_q == ST_E_WR);
		hs_waddr  = (state_q == ST_IDLE) ? {in_ri, in_ci} : {i_q, j_q};
		hs_wdata  = (state_q == ST_IDLE) ? in_hess_value : h_new.val;
		sy_we     = (state_q == ST_PREP_WR);
		wy_we     = (state_q == ST_DOT_END) && (pass_q == PS_HY);
		wt_we     = (state_q == ST_DOT_END) && (pass_q == PS_HTY);

		// reads are issued continuously, data follows in the next cycle
		if (state_q == ST_IDLE) begin
			cc_raddr = in_ri;
		end else if (state_q == ST_PREP_RD) begin
			cc_raddr = j_q;
		end else begin
			cc_raddr = i_q;
		end
		if (state_q == ST_IDLE) begin
			hs_raddr = {in_ri, in_ci};
		end else if (pass_q == PS_HTY) begin
			hs_raddr = {j_q, i_q};  // transposed walk for H^T y
		end else begin
			hs_raddr = {i_q, j_q};
		end
		vsel_raddr = (state_q == ST_E_ROW_RD) ? i_q : j_q;

		// shared multiplier operands
		mul_a = sv_rd;
		mul_b = sv_rd;
		case (state_q)
			ST_DOT_MUL: begin
				case (pass_q)
					PS_HY, PS_HTY: begin
						mul_a = hs_rd;
						mul_b = yv_rd;
					end
					PS_SY: begin
						mul_a = sv_rd;
						mul_b = yv_rd;
					end
					PS_YHY: begin
						mul_a = yv_rd;
						mul_b = wy_rd;
					end
					PS_STEP: begin
						mul_a = hs_rd;
						mul_b = cg_rd;
					end
					default: begin
						mul_a = hs_rd;
						mul_b = yv_rd;
					end
				endcase
			end
			ST_E_M1: begin
				mul_a = si_q;
				mul_b = sv_rd;
			end
			ST_E_M3: begin
				mul_a = c_q;
				mul_b = ss_q;
			end
			ST_E_M4: begin
				mul_a = si_q;
				mul_b = wt_rd;
			end
			ST_E_M5: begin
				mul_a = wyi_q;
				mul_b = sv_rd;
			end
			default: begin
				mul_a = sv_rd;
				mul_b = sv_rd;
			end
		endcase

		// divider operands
		div_start = (state_q == ST_C_DIV1) || (state_q == ST_C_DIV2) || (state_q == ST_E_DIV);
		case (state_q)
			ST_C_DIV1: div_num = DIV_NUM_W'(sy_q) + DIV_NUM_W'(yhy_q);
			ST_C_DIV2: div_num = DIV_NUM_W'(c_q);
			default:   div_num = DIV_NUM_W'(signed'(acc_sat.val));
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PS_HY;
			i_q         <= '0;
			j_q         <= '0;
			active_q    <= ACTIVE_RESET;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_ACTIVE: active_q <= cfg_wdata[4:0];
					REG_LIMIT:  limit_q  <= cfg_wdata;
					default:    active_q <= active_q;
				endcase
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q    <= '0;
						j_q    <= '0;
						pass_q <= (in_func == FN_STEP) ? PS_STEP : PS_HY;
					end
				end
				ST_PREP_WR: j_q <= last_j ? '0 : j_q + IW'(1);
				ST_DOT_ACC: begin
					if (!last_j) begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_DOT_END: begin
					j_q <= '0;
					case (pass_q)
						PS_HY: begin
							if (last_i) begin
								pass_q <= PS_HTY;
								i_q    <= '0;
							end else begin
								i_q <= i_q + IW'(1);
							end
						end
						PS_HTY: begin
							if (last_i) begin
								pass_q <= PS_SY;
								i_q    <= '0;
							end else begin
								i_q <= i_q + IW'(1);
							end
						end
						PS_SY:   pass_q <= PS_YHY;
						PS_YHY:  i_q <= '0;
						default: i_q <= i_q;
					endcase
				end
				ST_E_ROW_LAT: j_q <= '0;
				ST_E_WR: begin
					if (!last_j) begin
						j_q <= j_q + IW'(1);
					end else if (!last_i) begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_S_CWR: begin
					i_q <= i_q + IW'(1);
					j_q <= '0;
				end
				ST_FINISH: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: i_q <= i_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					acc_q        <= '0;
					sat_q        <= 1'b0;
					rd_hess_q    <= (in_func == FN_READ_HESS);
					rd_ok_q      <= (in_func == FN_READ_HESS) ? (row_ok && col_ok) : row_ok;
					use_sat_q    <= (in_func == FN_STEP) || ((in_func == FN_UPDATE) && !n_zero);
					res_status_q <= (in_func == FN_UPDATE) ? STAT_SKIP : STAT_OK;
					res_data_q   <= '0;
				end
			end
			ST_RD_OUT: begin
				if (rd_ok_q) begin
					res_data_q <= rd_hess_q ? hs_rd : cc_rd;
				end
			end
			ST_PREP_WR: sat_q <= sat_q | s_sat.ovf | y_sat.ovf;
			ST_DOT_ACC: acc_q <= acc_q + ACC_W'(fx_w);
			ST_DOT_END: begin
				acc_q <= '0;
				case (pass_q)
					PS_HY, PS_HTY: sat_q <= sat_q | acc_sat.ovf;
					PS_SY: begin
						sy_q  <= acc_sat.val;
						sat_q <= sat_q | acc_sat.ovf;
					end
					PS_YHY: begin
						yhy_q <= acc_sat.val;
						sat_q <= sat_q | acc_sat.ovf;
						if (sy_q == '0) begin
							use_sat_q <= 1'b0;  // skipped update reports skip only
						end
					end
					PS_STEP: d_q <= DATA_W'(clamp_w);
					default: acc_q <= '0;
				endcase
			end
			ST_C_WAIT1, ST_C_WAIT2: begin
				if (div_stat.done) begin
					c_q   <= q_sat.val;
					sat_q <= sat_q | q_sat.ovf;
				end
			end
			ST_E_ROW_LAT: begin
				si_q  <= sv_rd;
				wyi_q <= wy_rd;
			end
			ST_E_M2: begin
				ss_q  <= fx_sat.val;
				sat_q <= sat_q | fx_sat.ovf;
			end
			ST_E_M4: begin
				a_q   <= fx_sat.val;
				sat_q <= sat_q | fx_sat.ovf;
			end
			ST_E_M5:  acc_q <= ACC_W'(fx_w);
			ST_E_M6:  acc_q <= acc_q + ACC_W'(fx_w);
			ST_E_DIV: sat_q <= sat_q | acc_sat.ovf;
			ST_E_WR: begin
				sat_q <= sat_q | q_sat.ovf | h_new.ovf;
				acc_q <= '0;
			end
			ST_S_CWR: begin
				sat_q <= sat_q | coord_sum.ovf;
				acc_q <= '0;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= res_data_q;
					if (use_sat_q) begin
						out_status_q <= sat_q ? STAT_SAT : STAT_OK;
					end else begin
						out_status_q <= res_status_q;
					end
				end
			end
			default: sat_q <= sat_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_status_q, out_data_q};

	// storage
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_cur_coords (
		.clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
		.raddr(cc_raddr), .rdata(cc_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_old_coords (
		.clk(clk), .we(vec_we), .waddr(in_ri), .wdata(in_prev_coord),
		.raddr(j_q), .rdata(oc_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_cur_grads (
		.clk(clk), .we(vec_we), .waddr(in_ri), .wdata(in_grad),
		.raddr(j_q), .rdata(cg_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_old_grads (
		.clk(clk), .we(vec_we), .waddr(in_ri), .wdata(in_prev_grad),
		.raddr(j_q), .rdata(og_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(HDEPTH)) u_inv_hessian (
		.clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
		.raddr(hs_raddr), .rdata(hs_rd)
	);
	// s and y differences, rebuilt at every update
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_s_vec (
		.clk(clk), .we(sy_we), .waddr(j_q), .wdata(s_sat.val),
		.raddr(vsel_raddr), .rdata(sv_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_y_vec (
		.clk(clk), .we(sy_we), .waddr(j_q), .wdata(y_sat.val),
		.raddr(j_q), .rdata(yv_rd)
	);
	// work vectors: H y and H^T y
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_hy_vec (
		.clk(clk), .we(wy_we), .waddr(i_q), .wdata(acc_sat.val),
		.raddr(vsel_raddr), .rdata(wy_rd)
	);
	bfgs_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_hty_vec (
		.clk(clk), .we(wt_we), .waddr(i_q), .wdata(acc_sat.val),
		.raddr(j_q), .rdata(wt_rd)
	);

	// shared divider for c and the per entry correction term
	bfgs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sy_q), .quot(div_quot), .stat(div_stat)
	);

	// the divider is only started when it is free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// matrix entries are written by an update only when sy is nonzero
	a_sy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_WR) |-> (sy_q != '0))
		else $error("matrix written with zero sy");

	// a finished command waits while the previous result is still held
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && m_tvalid && !m_tready) |=> (state_q == ST_FINISH))
		else $error("result dropped while output stalled");

endmodule
